[rtl/eefe_pkg.sv]
// ============================================================================
// eefe_pkg: shared constants, types and functions
// Field widths, register indexes, CORDIC constants and the sideband
// structures carried along the excitation energy pipeline.
// ============================================================================
package eefe_pkg;

    // Field and register widths
    localparam int W_MASS     = 34;
    localparam int W_KIN      = 28;
    localparam int W_VEL      = 25;
    localparam int W_GAM      = 27;
    localparam int W_DEF      = 24;
    localparam int W_ENERGY   = 28;
    localparam int W_ANGLE    = 17;
    localparam int W_EXC      = 35;
    localparam int W_CFG_IDX  = 4;
    localparam int W_CFG_DATA = 34;

    // Internal widths
    localparam int W_EM    = 35;   // ejectile mass plus energy
    localparam int W_A     = 72;   // invariant term A, zero extended for the root
    localparam int W_V1    = 72;   // A + M2^2
    localparam int W_P     = 32;   // ejectile momentum
    localparam int W_VP    = 33;   // V * P
    localparam int W_TG    = 64;   // 2 * G * sqrt(A)
    localparam int W_CORD  = 36;   // CORDIC x, y, z
    localparam int W_CMAG  = 31;   // |cos| in Q30
    localparam int W_TERM  = 35;   // V * P * cos, signed
    localparam int W_B     = 37;   // B, signed
    localparam int W_MAG   = 36;   // |B|
    localparam int W_PM    = 100;  // 2G sqrt(A) |B| before the shift
    localparam int W_PS    = 76;   // same after the 24 bit shift
    localparam int W_V2    = 78;   // final root argument
    localparam int W_ROOT  = 39;   // final root

    // Saturation limit of the excitation field
    localparam logic [W_ROOT-1:0] EXC_MAX = W_ROOT'((64'd1 << (W_EXC - 1)) - 64'd1);

    // Configuration register indexes
    typedef enum logic [W_CFG_IDX-1:0] {
        CFG_MASS_BEAM     = 4'd0,
        CFG_MASS_TARGET   = 4'd1,
        CFG_MASS_EJECTILE = 4'd2,
        CFG_MASS_RECOIL   = 4'd3,
        CFG_BEAM_KINETIC  = 4'd4,
        CFG_CM_VELOCITY   = 4'd5,
        CFG_CM_GAMMA      = 4'd6,
        CFG_DEFAULT_EXC   = 4'd7
    } t_cfg_idx;

    localparam logic [W_GAM-1:0] CM_GAMMA_RESET = 27'd16777216;

    // arctan(2^-sh) in Q62 by the alternating series, sh >= 1
    function automatic logic [63:0] atan62_pow2(input int sh);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] t;
        p   = 64'h4000_0000_0000_0000 >> sh;
        sum = '0;
        for (int k = 0; k < 64; k++) begin
            if (p != 0) begin
                t = p / 64'(2 * k + 1);
                if (k % 2 == 1) sum = sum - t;
                else            sum = sum + t;
                p = p >> (2 * sh);
            end
        end
        return sum;
    endfunction

    // arctan(1/3) in Q62 by the alternating series
    function automatic logic [63:0] atan62_three();
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] t;
        p   = 64'h1555_5555_5555_5555;
        sum = '0;
        for (int k = 0; k < 64; k++) begin
            if (p != 0) begin
                t = p / 64'(2 * k + 1);
                if (k % 2 == 1) sum = sum - t;
                else            sum = sum + t;
                p = p / 64'd9;
            end
        end
        return sum;
    endfunction

    // pi/4 in Q62
    localparam logic [63:0] QUARTER_Q62 = atan62_pow2(1) + atan62_three();
    // pi/4 in Q48, scales the remainder angle
    localparam logic [47:0] PI46 = 48'(QUARTER_Q62 >> 14);

    // Per-step CORDIC angle in Q32
    function automatic logic [63:0] cordic_atan(input int i);
        logic [63:0] v;
        if (i == 0) v = QUARTER_Q62 >> 30;
        else        v = atan62_pow2(i) >> 30;
        return v;
    endfunction

    localparam logic signed [W_CORD-1:0] CORDIC_X0 = 36'sh0_9B74_EDA8;
    localparam logic signed [W_CORD-1:0] ONE_Q30   = 36'sh0_4000_0000;

    // Sideband of the front end and momentum root
    typedef struct packed {
        logic                 sp;   // zero energy and zero angle
        logic [W_EM-1:0]      em;
        logic [W_ANGLE-1:0]   ang;
    } t_front;

    // Sideband through the CORDIC
    typedef struct packed {
        logic                 sp;
        logic [W_EM-1:0]      em;
        logic [W_V1-1:0]      v1;
        logic [W_VP-1:0]      vp;
        logic [W_TG-1:0]      tg;
        logic [1:0]           quad;
    } t_cside;

    // Sideband through the V*P*cos product and the B stages
    typedef struct packed {
        logic                 sp;
        logic [W_EM-1:0]      em;
        logic [W_V1-1:0]      v1;
        logic [W_TG-1:0]      tg;
        logic                 cneg;
    } t_tside;

    // Sideband through the 2G sqrt(A) |B| product
    typedef struct packed {
        logic                 sp;
        logic [W_V1-1:0]      v1;
        logic                 bneg;
    } t_pside;

    // Sideband through the final root
    typedef struct packed {
        logic                 sp;
        logic                 inv;
    } t_vside;

endpackage

[rtl/eefe_mul.sv]
// ============================================================================
// eefe_mul: two-stage unsigned multiplier
// Splits both operands into 32-bit chunks, registers the partial products,
// then sums them. Valid and a sideband word travel with the operands.
// ============================================================================
module eefe_mul #(
    parameter int WA = 32,
    parameter int WB = 32,
    parameter int SW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [WA-1:0]      i_a,
    input  logic [WB-1:0]      i_b,
    input  logic [SW-1:0]      i_side,
    output logic               o_vld,
    output logic [WA+WB-1:0]   o_prod,
    output logic [SW-1:0]      o_side
);

    localparam int NA  = (WA + 31) / 32;
    localparam int NB  = (WB + 31) / 32;
    localparam int NP  = NA * NB;
    localparam int WAX = NA * 32;
    localparam int WBX = NB * 32;
    localparam int WP  = WA + WB;
    localparam int WS  = WAX + WBX;

    logic [WAX-1:0] a_ext;
    logic [WBX-1:0] b_ext;
    logic [63:0]    r_pp [NP];
    logic           r_vld1;
    logic           r_vld2;
    logic [SW-1:0]  r_side1;
    logic [SW-1:0]  r_side2;
    logic [WP-1:0]  r_prod;
    logic [WP-1:0]  n_prod;
    logic [WS-1:0]  acc;

    assign a_ext = WAX'(i_a);
    assign b_ext = WBX'(i_b);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    // stage 1: 32x32 partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i*NB+j] <= 64'(a_ext[32*i +: 32]) * 64'(b_ext[32*j +: 32]);
                end
            end
            r_side1 <= i_side;
        end
    end

    // stage 2: weighted sum of the partial products
    always_comb begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                acc = acc + (WS'(r_pp[i*NB+j]) << (32 * (i + j)));
            end
        end
        n_prod = acc[WP-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_side2 <= r_side1;
        end
    end

    assign o_vld  = r_vld2;
    assign o_prod = r_prod;
    assign o_side = r_side2;

endmodule

[rtl/eefe_sqrt.sv]
// ============================================================================
// eefe_sqrt: pipelined floor square root
// One result bit per stage, most significant first, keeping the exact
// remainder; valid and a sideband travel along.
// ============================================================================
module eefe_sqrt #(
    parameter int WV = 72,
    parameter int SW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [WV-1:0]         i_val,
    input  logic [SW-1:0]         i_side,
    output logic                  o_vld,
    output logic [(WV+1)/2-1:0]   o_root,
    output logic [SW-1:0]         o_side
);

    localparam int WR = (WV + 1) / 2;
    localparam int WT = 2 * WR + 1;

    logic [WT-1:0] r_rem  [WR];
    logic [WR-1:0] r_root [WR];
    logic          r_vld  [WR];
    logic [SW-1:0] r_side [WR];

    for (genvar k = 0; k < WR; k++) begin : g_stg
        localparam int B = WR - 1 - k;

        logic [WT-1:0] rem_in;
        logic [WT-1:0] trial;
        logic [WR-1:0] root_in;
        logic          vld_in;
        logic [SW-1:0] side_in;

        if (k == 0) begin : g_first
            assign rem_in  = WT'(i_val);
            assign root_in = '0;
            assign vld_in  = i_vld;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign vld_in  = r_vld[k-1];
            assign side_in = r_side[k-1];
        end

        // (r + 2^B)^2 - r^2
        assign trial = (WT'(root_in) << (B + 1)) + (WT'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        // keep the bit when the remainder covers the trial
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= trial) begin
                    r_rem[k]  <= rem_in - trial;
                    r_root[k] <= root_in | (WR'(1) << B);
                end else begin
                    r_rem[k]  <= rem_in;
                    r_root[k] <= root_in;
                end
                r_side[k] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[WR-1];
    assign o_root = r_root[WR-1];
    assign o_side = r_side[WR-1];

endmodule

[rtl/excitation_energy_from_ejectile.sv]
// ============================================================================
// excitation_energy_from_ejectile: recoil excitation by two-body missing mass
// Takes an ejectile lab energy and angle, returns the recoil excitation.
// ============================================================================
// Fully pipelined: one item is accepted per clock unless the pipe holds.
// The pipe runs through three bit-per-stage square roots (36, 36 and 39
// stages, the first two side by side), the CORDIC cosine (CORDIC_STEPS
// stages) and four two-stage chunked multipliers in series. The whole
// pipe advances together; it only holds while a finished item waits on
// i_stall, and o_stall follows from that. Configuration registers are
// written through the cfg port, which is always ready, and must only change
// while no item is in flight.
module excitation_energy_from_ejectile #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input items
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [eefe_pkg::W_ENERGY-1:0]          i_ejectile_energy,
    input  logic [eefe_pkg::W_ANGLE-1:0]           i_lab_angle,
    // result items
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [eefe_pkg::W_EXC-1:0]      o_excitation,
    output logic                                   o_invalid,
    // configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [eefe_pkg::W_CFG_IDX-1:0]         i_cfg_index,
    input  logic [eefe_pkg::W_CFG_DATA-1:0]        i_cfg_data
);

    import eefe_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [W_MASS-1:0] r_mass_beam;
    logic [W_MASS-1:0] r_mass_target;
    logic [W_MASS-1:0] r_mass_ejectile;
    logic [W_MASS-1:0] r_mass_recoil;
    logic [W_KIN-1:0]  r_beam_kinetic;
    logic [W_VEL-1:0]  r_cm_velocity;
    logic [W_GAM-1:0]  r_cm_gamma;
    logic [W_DEF-1:0]  r_default_exc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass_beam     <= '0;
            r_mass_target   <= '0;
            r_mass_ejectile <= '0;
            r_mass_recoil   <= '0;
            r_beam_kinetic  <= '0;
            r_cm_velocity   <= '0;
            r_cm_gamma      <= CM_GAMMA_RESET;
            r_default_exc   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MASS_BEAM:     r_mass_beam     <= i_cfg_data[W_MASS-1:0];
                CFG_MASS_TARGET:   r_mass_target   <= i_cfg_data[W_MASS-1:0];
                CFG_MASS_EJECTILE: r_mass_ejectile <= i_cfg_data[W_MASS-1:0];
                CFG_MASS_RECOIL:   r_mass_recoil   <= i_cfg_data[W_MASS-1:0];
                CFG_BEAM_KINETIC:  r_beam_kinetic  <= i_cfg_data[W_KIN-1:0];
                CFG_CM_VELOCITY:   r_cm_velocity   <= i_cfg_data[W_VEL-1:0];
                CFG_CM_GAMMA:      r_cm_gamma      <= i_cfg_data[W_GAM-1:0];
                CFG_DEFAULT_EXC:   r_default_exc   <= i_cfg_data[W_DEF-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline advance: hold only when a finished item is stalled
    // ------------------------------------------------------------------
    logic en;
    logic r_out_vld;

    assign en      = !r_out_vld || !i_stall;
    assign o_stall = !en;

    // ------------------------------------------------------------------
    // front: five products in parallel
    // ------------------------------------------------------------------
    logic [W_MASS:0]   sum01;
    logic [W_MASS:0]   m1x2;
    logic [W_MASS:0]   m2x2;
    t_front            front_in;

    assign sum01        = {1'b0, r_mass_beam} + {1'b0, r_mass_target};
    assign m1x2         = {r_mass_target, 1'b0};
    assign m2x2         = {r_mass_ejectile, 1'b0};
    assign front_in.sp  = (i_ejectile_energy == '0) && (i_lab_angle == '0);
    assign front_in.em  = W_EM'(r_mass_ejectile) + W_EM'(i_ejectile_energy);
    assign front_in.ang = i_lab_angle;

    logic                          ee_vld;
    logic [2*W_ENERGY-1:0]         ee_prod;
    t_front                        ee_side;
    logic [W_MASS+1+W_ENERGY-1:0]  me_prod;
    logic [2*W_MASS+1:0]           ss_prod;
    logic [W_MASS+1+W_KIN-1:0]     mt_prod;
    logic [2*W_MASS-1:0]           m22_prod;

    eefe_mul #(.WA(W_ENERGY), .WB(W_ENERGY), .SW($bits(t_front))) u_mul_ee (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(i_valid),
        .i_a(i_ejectile_energy), .i_b(i_ejectile_energy), .i_side(front_in),
        .o_vld(ee_vld), .o_prod(ee_prod), .o_side(ee_side)
    );

    eefe_mul #(.WA(W_MASS + 1), .WB(W_ENERGY), .SW(1)) u_mul_me (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(i_valid),
        .i_a(m2x2), .i_b(i_ejectile_energy), .i_side(1'b0),
        .o_vld(), .o_prod(me_prod), .o_side()
    );

    eefe_mul #(.WA(W_MASS + 1), .WB(W_MASS + 1), .SW(1)) u_mul_ss (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(i_valid),
        .i_a(sum01), .i_b(sum01), .i_side(1'b0),
        .o_vld(), .o_prod(ss_prod), .o_side()
    );

    eefe_mul #(.WA(W_MASS + 1), .WB(W_KIN), .SW(1)) u_mul_mt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(i_valid),
        .i_a(m1x2), .i_b(r_beam_kinetic), .i_side(1'b0),
        .o_vld(), .o_prod(mt_prod), .o_side()
    );

    eefe_mul #(.WA(W_MASS), .WB(W_MASS), .SW(1)) u_mul_m22 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(i_valid),
        .i_a(r_mass_ejectile), .i_b(r_mass_ejectile), .i_side(1'b0),
        .o_vld(), .o_prod(m22_prod), .o_side()
    );

    // ------------------------------------------------------------------
    // sums: P^2 argument, A, A + M2^2
    // ------------------------------------------------------------------
    logic [W_A-1:0]   r_pp;
    logic [W_A-1:0]   r_a;
    logic [W_V1-1:0]  r_v1;
    t_front           r_add_side;
    logic             r_add_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_vld <= 1'b0;
        end else if (en) begin
            r_add_vld <= ee_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pp       <= W_A'(ee_prod) + W_A'(me_prod);
            r_a        <= W_A'(ss_prod) + W_A'(mt_prod);
            r_v1       <= W_V1'(ss_prod) + W_V1'(mt_prod) + W_V1'(m22_prod);
            r_add_side <= ee_side;
        end
    end

    // ------------------------------------------------------------------
    // roots of A and of the momentum argument, side by side
    // ------------------------------------------------------------------
    logic [W_A/2-1:0]  sqa_root;
    logic [W_V1-1:0]   sqa_v1;
    logic              sqp_vld;
    logic [W_A/2-1:0]  sqp_root;
    t_front            sqp_side;

    eefe_sqrt #(.WV(W_A), .SW(W_V1)) u_sqrt_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_add_vld),
        .i_val(r_a), .i_side(r_v1),
        .o_vld(), .o_root(sqa_root), .o_side(sqa_v1)
    );

    eefe_sqrt #(.WV(W_A), .SW($bits(t_front))) u_sqrt_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_add_vld),
        .i_val(r_pp), .i_side(r_add_side),
        .o_vld(sqp_vld), .o_root(sqp_root), .o_side(sqp_side)
    );

    // ------------------------------------------------------------------
    // V * P and 2 * G * sqrt(A)
    // ------------------------------------------------------------------
    logic                    vp_vld;
    logic [W_VEL+W_P-1:0]    vp_prod;
    t_front                  vp_side;
    logic [W_TG-1:0]         tg_prod;
    logic [W_V1-1:0]         tg_v1;

    eefe_mul #(.WA(W_VEL), .WB(W_P), .SW($bits(t_front))) u_mul_vp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(sqp_vld),
        .i_a(r_cm_velocity), .i_b(sqp_root[W_P-1:0]), .i_side(sqp_side),
        .o_vld(vp_vld), .o_prod(vp_prod), .o_side(vp_side)
    );

    eefe_mul #(.WA(W_GAM + 1), .WB(W_A / 2), .SW(W_V1)) u_mul_tg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(sqp_vld),
        .i_a({r_cm_gamma, 1'b0}), .i_b(sqa_root), .i_side(sqa_v1),
        .o_vld(), .o_prod(tg_prod), .o_side(tg_v1)
    );

    // ------------------------------------------------------------------
    // remainder angle to Q32 radians, in two partial products
    // ------------------------------------------------------------------
    t_cside         z_side_in;
    logic [38:0]    r_zhi;
    logic [38:0]    r_zlo;
    t_cside         r_z1_side;
    logic           r_z1_vld;
    logic [63:0]    zsum;
    logic signed [W_CORD-1:0] r_z;
    t_cside         r_z_side;
    logic           r_z_vld;

    assign z_side_in.sp   = vp_side.sp;
    assign z_side_in.em   = vp_side.em;
    assign z_side_in.v1   = tg_v1;
    assign z_side_in.vp   = vp_prod[W_VEL+W_P-1:24];
    assign z_side_in.tg   = tg_prod;
    assign z_side_in.quad = vp_side.ang[16:15];

    assign zsum = (64'(r_zhi) << 24) + 64'(r_zlo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z1_vld <= 1'b0;
            r_z_vld  <= 1'b0;
        end else if (en) begin
            r_z1_vld <= vp_vld;
            r_z_vld  <= r_z1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zhi     <= 39'(vp_side.ang[14:0]) * 39'(PI46[47:24]);
            r_zlo     <= 39'(vp_side.ang[14:0]) * 39'(PI46[23:0]);
            r_z1_side <= z_side_in;
            r_z       <= $signed({2'b00, zsum[63:30]});
            r_z_side  <= r_z1_side;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC rotation, one step per stage
    // ------------------------------------------------------------------
    logic signed [W_CORD-1:0] r_cx [CORDIC_STEPS];
    logic signed [W_CORD-1:0] r_cy [CORDIC_STEPS];
    logic signed [W_CORD-1:0] r_cz [CORDIC_STEPS];
    logic                     r_cvld [CORDIC_STEPS];
    t_cside                   r_cside [CORDIC_STEPS];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        localparam logic [63:0] DA64 = cordic_atan(k);
        localparam logic signed [W_CORD-1:0] DA = W_CORD'(DA64);

        logic signed [W_CORD-1:0] x_in;
        logic signed [W_CORD-1:0] y_in;
        logic signed [W_CORD-1:0] z_in;
        logic                     vld_in;
        t_cside                   side_in;

        if (k == 0) begin : g_first
            assign x_in    = CORDIC_X0;
            assign y_in    = '0;
            assign z_in    = r_z;
            assign vld_in  = r_z_vld;
            assign side_in = r_z_side;
        end else begin : g_next
            assign x_in    = r_cx[k-1];
            assign y_in    = r_cy[k-1];
            assign z_in    = r_cz[k-1];
            assign vld_in  = r_cvld[k-1];
            assign side_in = r_cside[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cvld[k] <= 1'b0;
            end else if (en) begin
                r_cvld[k] <= vld_in;
            end
        end

        // rotate toward zero residual angle
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (z_in >= 0) begin
                    r_cx[k] <= x_in - (y_in >>> k);
                    r_cy[k] <= y_in + (x_in >>> k);
                    r_cz[k] <= z_in - DA;
                end else begin
                    r_cx[k] <= x_in + (y_in >>> k);
                    r_cy[k] <= y_in - (x_in >>> k);
                    r_cz[k] <= z_in + DA;
                end
                r_cside[k] <= side_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // quadrant fold, scale to Q30, clamp; split into sign and magnitude
    // ------------------------------------------------------------------
    logic signed [W_CORD-1:0] cq;
    logic signed [W_CORD-1:0] cs;
    logic signed [W_CORD-1:0] cc;
    logic signed [W_CORD-1:0] cabs;
    logic [W_CMAG-1:0]        r_cmag;
    logic                     r_cneg;
    t_cside                   r_cos_side;
    logic                     r_cos_vld;
    t_cside                   cl_side;

    assign cl_side = r_cside[CORDIC_STEPS-1];

    always_comb begin
        case (cl_side.quad)
            2'd0:    cq = r_cx[CORDIC_STEPS-1];
            2'd1:    cq = -r_cy[CORDIC_STEPS-1];
            2'd2:    cq = -r_cx[CORDIC_STEPS-1];
            default: cq = r_cy[CORDIC_STEPS-1];
        endcase
        cs = cq >>> 2;
        if (cs > ONE_Q30)       cc = ONE_Q30;
        else if (cs < -ONE_Q30) cc = -ONE_Q30;
        else                    cc = cs;
        cabs = (cc < 0) ? -cc : cc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_vld <= 1'b0;
        end else if (en) begin
            r_cos_vld <= r_cvld[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmag     <= cabs[W_CMAG-1:0];
            r_cneg     <= (cc < 0);
            r_cos_side <= cl_side;
        end
    end

    // ------------------------------------------------------------------
    // V * P * |cos|
    // ------------------------------------------------------------------
    t_tside                    tc_side_in;
    logic                      tc_vld;
    logic [W_VP+W_CMAG-1:0]    tc_prod;
    t_tside                    tc_side;

    assign tc_side_in.sp   = r_cos_side.sp;
    assign tc_side_in.em   = r_cos_side.em;
    assign tc_side_in.v1   = r_cos_side.v1;
    assign tc_side_in.tg   = r_cos_side.tg;
    assign tc_side_in.cneg = r_cneg;

    eefe_mul #(.WA(W_VP), .WB(W_CMAG), .SW($bits(t_tside))) u_mul_tc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_cos_vld),
        .i_a(r_cos_side.vp), .i_b(r_cmag), .i_side(tc_side_in),
        .o_vld(tc_vld), .o_prod(tc_prod), .o_side(tc_side)
    );

    // ------------------------------------------------------------------
    // term = floor(V*P*cos / 2^30), then B = M2 + e - term
    // ------------------------------------------------------------------
    logic signed [W_VP+W_CMAG:0] tsig;
    logic signed [W_VP+W_CMAG:0] tsh;
    logic signed [W_TERM-1:0]    r_term;
    t_tside                      r_term_side;
    logic                        r_term_vld;
    logic signed [W_B-1:0]       bval;
    logic signed [W_B-1:0]       babs;
    logic [W_MAG-1:0]            r_mag;
    logic [W_TG-1:0]             r_b_tg;
    t_pside                      r_b_side;
    logic                        r_b_vld;

    assign tsig = tc_side.cneg ? -$signed({1'b0, tc_prod}) : $signed({1'b0, tc_prod});
    assign tsh  = tsig >>> 30;
    assign bval = $signed({2'b00, r_term_side.em}) - W_B'(r_term);
    assign babs = (bval < 0) ? -bval : bval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_vld <= 1'b0;
            r_b_vld    <= 1'b0;
        end else if (en) begin
            r_term_vld <= tc_vld;
            r_b_vld    <= r_term_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_term        <= tsh[W_TERM-1:0];
            r_term_side   <= tc_side;
            r_mag         <= babs[W_MAG-1:0];
            r_b_tg        <= r_term_side.tg;
            r_b_side.sp   <= r_term_side.sp;
            r_b_side.v1   <= r_term_side.v1;
            r_b_side.bneg <= (bval < 0);
        end
    end

    // ------------------------------------------------------------------
    // 2 * G * sqrt(A) * |B|
    // ------------------------------------------------------------------
    logic              pm_vld;
    logic [W_PM-1:0]   pm_prod;
    t_pside            pm_side;

    eefe_mul #(.WA(W_TG), .WB(W_MAG), .SW($bits(t_pside))) u_mul_pm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_b_vld),
        .i_a(r_b_tg), .i_b(r_mag), .i_side(r_b_side),
        .o_vld(pm_vld), .o_prod(pm_prod), .o_side(pm_side)
    );

    // ------------------------------------------------------------------
    // final root argument; negative argument flags the item invalid
    // ------------------------------------------------------------------
    logic [W_V2-1:0]  v1x;
    logic [W_V2-1:0]  psx;
    logic [W_V2-1:0]  r_v2;
    t_vside           r_v2_side;
    logic             r_v2_vld;

    assign v1x = W_V2'(pm_side.v1);
    assign psx = W_V2'(pm_prod[W_PM-1:24]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2_vld <= 1'b0;
        end else if (en) begin
            r_v2_vld <= pm_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v2_side.sp <= pm_side.sp;
            if (pm_side.bneg) begin
                r_v2          <= v1x + psx;
                r_v2_side.inv <= 1'b0;
            end else begin
                r_v2          <= v1x - psx;
                r_v2_side.inv <= (v1x < psx);
            end
        end
    end

    logic              sqv_vld;
    logic [W_ROOT-1:0] sqv_root;
    t_vside            sqv_side;

    eefe_sqrt #(.WV(W_V2), .SW($bits(t_vside))) u_sqrt_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_v2_vld),
        .i_val(r_v2), .i_side(r_v2_side),
        .o_vld(sqv_vld), .o_root(sqv_root), .o_side(sqv_side)
    );

    // ------------------------------------------------------------------
    // output register: default, invalid or saturated root - M3
    // ------------------------------------------------------------------
    logic [W_ROOT-1:0]   m3x;
    logic [W_ROOT-1:0]   dpos;
    logic [W_ROOT-1:0]   dneg;
    logic [W_EXC-1:0]    n_exc;
    logic                n_inv;
    logic [W_EXC-1:0]    r_exc;
    logic                r_inv;

    assign m3x  = W_ROOT'(r_mass_recoil);
    assign dpos = sqv_root - m3x;
    assign dneg = m3x - sqv_root;

    always_comb begin
        if (sqv_side.sp) begin
            n_exc = {{(W_EXC - W_DEF){r_default_exc[W_DEF-1]}}, r_default_exc};
            n_inv = 1'b0;
        end else if (sqv_side.inv) begin
            n_exc = '0;
            n_inv = 1'b1;
        end else if (sqv_root >= m3x) begin
            n_exc = (dpos > EXC_MAX) ? EXC_MAX[W_EXC-1:0] : dpos[W_EXC-1:0];
            n_inv = 1'b0;
        end else begin
            n_exc = W_EXC'(0) - dneg[W_EXC-1:0];
            n_inv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= sqv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_exc <= n_exc;
            r_inv <= n_inv;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_excitation = $signed(r_exc);
    assign o_invalid    = r_inv;

endmodule
